// ----- rtl/core/mailbox_command_register_device_defines.svh -----
// ----------------------------------------------------------------------------
// Mailbox command register device: assertion macros
// Shared forms for the port checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_COMMAND_REGISTER_DEVICE_DEFINES_SVH
`define MAILBOX_COMMAND_REGISTER_DEVICE_DEFINES_SVH

// The consequent is checked at the same edge as the antecedent.
`define MCRD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox port check failed");

// The consequent is checked at the edge that follows the antecedent.
`define MCRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox port check failed");

`endif

// ----- rtl/core/mcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// Mailbox command register device: package
// Shared widths, codes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
package mcrd_pkg;

  localparam int DATA_W            = 32;
  localparam int IDX_W             = 14;
  localparam int CFG_IW            = 3;
  localparam int MAILBOX_WORDS_DEF = 16384;

  // Bit that marks cheats as used in the cheat status bytes.
  localparam logic [7:0] USED_CHEATS_BIT = 8'h01;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_MARK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_VER_MM   = 3'd0,
    CFG_VER_PAT  = 3'd1,
    CFG_REND_K   = 3'd2,
    CFG_REND_F   = 3'd3,
    CFG_SS_TOKEN = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_CMD_RD1,
    S_CMD_RD2,
    S_CMD_CALC,
    S_CMD_WR
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic addr_go;
    logic exec;
    logic rd1;
    logic rd2;
    logic calc;
    logic cmd_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cmd_trig;
    logic wr_last;
  } dp_sts_t;

endpackage

// ----- rtl/core/mcrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Mailbox controller
// Sequences the clearing pass, each transaction and the command write-back.
// ----------------------------------------------------------------------------
module mcrd_ctrl
  import mcrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t dp_sts,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    dp_cmd        = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        dp_cmd.clr_wr = 1'b1;
        if (dp_sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = S_ADDR;
        end
      end
      S_ADDR: begin
        dp_cmd.addr_go = 1'b1;
        state_nxt      = S_EXEC;
      end
      S_EXEC: begin
        // The result register must be free before the access is carried out.
        if (out_free) begin
          dp_cmd.exec   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dp_sts.cmd_trig ? S_CMD_RD1 : S_IDLE;
        end
      end
      S_CMD_RD1: begin
        dp_cmd.rd1 = 1'b1;
        state_nxt  = S_CMD_RD2;
      end
      S_CMD_RD2: begin
        dp_cmd.rd2 = 1'b1;
        state_nxt  = S_CMD_CALC;
      end
      S_CMD_CALC: begin
        dp_cmd.calc = 1'b1;
        state_nxt   = S_CMD_WR;
      end
      S_CMD_WR: begin
        dp_cmd.cmd_wr = 1'b1;
        if (dp_sts.wr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/mcrd_dp.sv -----
// ----------------------------------------------------------------------------
// Mailbox datapath
// Word store, index wrap, masked merge, command evaluation and write-back.
// ----------------------------------------------------------------------------
module mcrd_dp
  import mcrd_pkg::*;
#(
  parameter int MAILBOX_WORDS = MAILBOX_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           dp_cmd,
  output dp_sts_t           dp_sts,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_word_index,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [DATA_W-1:0] in_write_mask,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output logic [DATA_W-1:0] out_read_data
);

  localparam int AW = $clog2(MAILBOX_WORDS);
  localparam int SH = 28;
  // Reciprocal of the store depth; the quotient estimate is low by at most one.
  localparam logic [SH-1:0]  RECIP = SH'((64'd1 << SH) / MAILBOX_WORDS);
  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(MAILBOX_WORDS);

  localparam logic [15:0] MAX_PAYLOAD = 16'hFFFC;
  localparam logic [31:0] RSP_HELLO    = 32'h0050_0000;
  localparam logic [31:0] RSP_UNKNOWN  = 32'h0100_0000;
  localparam logic [31:0] RSP_OVERSIZE = 32'h0200_0000;
  localparam logic [31:0] RSP_NO_PIPE  = 32'h0300_0000;
  localparam logic [31:0] RSP_NO_REND  = 32'h0001_0000;
  localparam logic [31:0] RSP_VERSION  = 32'h0000_0006;
  localparam logic [31:0] RSP_SS       = 32'h0000_0004;

  localparam logic [7:0] CMD_HELLO     = 8'd0;
  localparam logic [7:0] CMD_VERSION   = 8'd1;
  localparam logic [7:0] CMD_SAVESTATE = 8'd2;
  localparam logic [7:0] CMD_CHEAT_USE = 8'd3;
  localparam logic [7:0] CMD_RENDERER  = 8'd4;
  localparam logic [7:0] CMD_CHEAT_ST  = 8'd5;
  localparam logic [7:0] CMD_CHEAT_ACK = 8'd6;

  // Renderer codes and their capability bits.
  localparam logic [2:0]  REND_K0 = 3'd0;
  localparam logic [2:0]  REND_K1 = 3'd1;
  localparam logic [2:0]  REND_K2 = 3'd2;
  localparam logic [2:0]  REND_K3 = 3'd3;
  localparam logic [2:0]  REND_K4 = 3'd4;
  localparam logic [2:0]  REND_K5 = 3'd5;
  localparam logic [31:0] CAP_UPSCALE = 32'h0000_0001;
  localparam logic [31:0] CAP_FBE     = 32'h0000_0002;
  localparam logic [31:0] CAP_DEPTH   = 32'h0000_0004;

  localparam logic [31:0] NAME_K0_A = 32'h476c_6964;
  localparam logic [31:0] NAME_K0_B = 32'h6536_3400;
  localparam logic [31:0] NAME_K1_A = 32'h5269_6365;
  localparam logic [31:0] NAME_K2_A = 32'h676c_6e36;
  localparam logic [31:0] NAME_K2_B = 32'h3400_0000;
  localparam logic [31:0] NAME_K3_A = 32'h416e_6772;
  localparam logic [31:0] NAME_K3_B = 32'h796c_696f;
  localparam logic [31:0] NAME_K3_C = 32'h6e00_0000;
  localparam logic [31:0] NAME_K4_A = 32'h5061_7261;
  localparam logic [31:0] NAME_K4_B = 32'h4c4c_456c;
  localparam logic [31:0] NAME_K5_A = 32'h4f47_5245;
  localparam logic [31:0] NAME_K5_B = 32'h654e_3634;

  // Configuration registers.
  logic [31:0] ver_mm_r;
  logic [15:0] ver_patch_r;
  logic [2:0]  rend_kind_r;
  logic [3:0]  rend_flags_r;
  logic [31:0] ss_token_r;

  // Transaction registers.
  req_t              req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  q_r;
  logic [31:0]       data_r;
  logic [31:0]       mask_r;
  logic [AW-1:0]     addr_r;
  logic [31:0]       out_data_r;

  // Command registers.
  logic [15:0] cmd_r;
  logic [15:0] size_r;
  logic [31:0] word1_r;
  logic [31:0] w_r [5];
  logic [4:0]  we_r;
  logic [2:0]  wr_cnt_r, wr_cnt_nxt;
  logic [AW-1:0] clr_cnt_r;

  logic [7:0] cheat_r, cheat_nxt;
  logic [7:0] frame_r, frame_nxt;
  logic       used_r, used_nxt;

  // Word store.
  logic [31:0]   mem [MAILBOX_WORDS];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_wdata;

  logic [IDX_W+SH-1:0] q_prod;
  logic [2*IDX_W:0]    qn_prod;
  logic [IDX_W:0]      rem;
  logic [IDX_W:0]      rem_fix;
  logic [AW-1:0]       addr_nxt;
  logic [31:0]         merged;

  logic [31:0] calc_w [5];
  logic [4:0]  calc_we;
  logic [7:0]  calc_cheat;
  logic [7:0]  ack_cheat;

  // Index wrap: quotient estimate at acceptance, remainder and fix-up after.
  assign q_prod  = (IDX_W + SH)'(in_word_index) * (IDX_W + SH)'(RECIP);
  assign qn_prod = (2 * IDX_W + 1)'(q_r) * (2 * IDX_W + 1)'(DEPTH);
  assign rem     = (IDX_W + 1)'(idx_r) - qn_prod[IDX_W:0];
  assign rem_fix = (rem >= DEPTH) ? (rem - DEPTH) : rem;
  assign addr_nxt = rem_fix[AW-1:0];

  assign merged = (data_r & mask_r) | (rd_data_r & ~mask_r);

  assign dp_sts.clr_last = (clr_cnt_r == AW'(MAILBOX_WORDS - 1));
  assign dp_sts.cmd_trig = (req_r == REQ_WRITE) && (addr_r == '0) &&
                           (mask_r[31:16] != 16'd0);
  assign dp_sts.wr_last  = (wr_cnt_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_mm_r     <= '0;
      ver_patch_r  <= '0;
      rend_kind_r  <= 3'd6;
      rend_flags_r <= '0;
      ss_token_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VER_MM:   ver_mm_r     <= cfg_data;
        CFG_VER_PAT:  ver_patch_r  <= cfg_data[15:0];
        CFG_REND_K:   rend_kind_r  <= cfg_data[2:0];
        CFG_REND_F:   rend_flags_r <= cfg_data[3:0];
        CFG_SS_TOKEN: ss_token_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      req_r  <= req_t'(in_req_type);
      idx_r  <= in_word_index;
      q_r    <= q_prod[IDX_W+SH-1:SH];
      data_r <= in_write_data;
      mask_r <= in_write_mask;
    end
    if (dp_cmd.addr_go) begin
      addr_r <= addr_nxt;
    end
    if (dp_cmd.exec) begin
      out_data_r <= (req_r == REQ_READ) ? rd_data_r : '0;
      cmd_r      <= merged[31:16];
      size_r     <= merged[15:0];
    end
    if (dp_cmd.rd1) begin
      word1_r <= rd_data_r;
    end
    if (dp_cmd.calc) begin
      for (int i = 0; i < 5; i++) begin
        w_r[i] <= calc_w[i];
      end
      we_r <= calc_we;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      wr_cnt_r  <= '0;
      cheat_r   <= '0;
      frame_r   <= '0;
      used_r    <= 1'b0;
    end else begin
      if (dp_cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      wr_cnt_r <= wr_cnt_nxt;
      cheat_r  <= cheat_nxt;
      frame_r  <= frame_nxt;
      used_r   <= used_nxt;
    end
  end

  always_comb begin
    wr_cnt_nxt = wr_cnt_r;
    if (dp_cmd.cmd_wr) begin
      wr_cnt_nxt = dp_sts.wr_last ? 3'd0 : wr_cnt_r + 3'd1;
    end
  end

  always_comb begin
    cheat_nxt = cheat_r;
    frame_nxt = frame_r;
    used_nxt  = used_r;
    if (dp_cmd.exec && (req_r == REQ_MARK)) begin
      used_nxt  = 1'b1;
      cheat_nxt = cheat_r | USED_CHEATS_BIT;
      frame_nxt = frame_r | USED_CHEATS_BIT;
    end else if (dp_cmd.calc) begin
      cheat_nxt = calc_cheat;
    end
  end

  // Command evaluation. Word 1 and the old word 2 have been read by now.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      calc_w[i] = '0;
    end
    calc_we    = 5'b00001;
    calc_cheat = cheat_r;
    ack_cheat  = '0;
    if (size_r > MAX_PAYLOAD) begin
      calc_w[0] = RSP_OVERSIZE;
    end else if (cmd_r[15:8] != 8'd0) begin
      calc_w[0] = RSP_NO_PIPE;
    end else begin
      case (cmd_r[7:0])
        CMD_HELLO: begin
          calc_w[0] = RSP_HELLO;
        end
        CMD_VERSION: begin
          calc_w[0] = RSP_VERSION;
          calc_w[1] = ver_mm_r;
          calc_w[2] = {ver_patch_r, rd_data_r[15:0]};
          calc_we   = 5'b00111;
        end
        CMD_SAVESTATE: begin
          calc_w[0] = RSP_SS;
          calc_w[1] = ss_token_r;
          calc_we   = 5'b00011;
        end
        CMD_CHEAT_USE: begin
          calc_w[0] = {15'd0, used_r, 16'd0};
        end
        CMD_RENDERER: begin
          calc_we = 5'b01111;
          case (rend_kind_r)
            REND_K0: begin
              calc_w[0] = 32'd12;
              calc_w[1] = 32'h0004_0000 | CAP_UPSCALE;
              calc_w[2] = NAME_K0_A;
              calc_w[3] = NAME_K0_B;
            end
            REND_K1: begin
              calc_w[0] = 32'd9;
              calc_w[1] = 32'h0006_0000 | CAP_UPSCALE;
              calc_w[2] = NAME_K1_A;
            end
            REND_K2: begin
              calc_w[0] = 32'd10;
              calc_w[1] = 32'h0007_0000 | CAP_UPSCALE;
              calc_w[2] = NAME_K2_A;
              calc_w[3] = NAME_K2_B;
            end
            REND_K3: begin
              calc_w[0] = 32'd14;
              calc_w[1] = 32'h0005_0000 | CAP_FBE | CAP_DEPTH;
              calc_w[2] = NAME_K3_A;
              calc_w[3] = NAME_K3_B;
              calc_w[4] = NAME_K3_C;
              calc_we   = 5'b11111;
            end
            REND_K4: begin
              calc_w[0] = 32'd13;
              calc_w[1] = 32'h0001_0000 | CAP_FBE | CAP_DEPTH |
                          (rend_flags_r[0] ? CAP_UPSCALE : 32'd0);
              calc_w[2] = NAME_K4_A;
              calc_w[3] = NAME_K4_B;
              calc_we   = 5'b11111;
            end
            REND_K5: begin
              // Legacy hacks select the short name and skip the last word.
              if (rend_flags_r[1]) begin
                calc_w[0] = 32'd9;
                calc_w[1] = 32'h0003_0000 | CAP_UPSCALE;
                calc_w[2] = NAME_K5_A;
              end else begin
                calc_w[0] = 32'd13;
                calc_w[1] = 32'h0002_0000 | CAP_UPSCALE;
                calc_w[2] = NAME_K0_A;
                calc_w[3] = NAME_K5_B;
                calc_we   = 5'b11111;
              end
              calc_w[1] = calc_w[1] | (rend_flags_r[2] ? CAP_FBE : 32'd0) |
                          (rend_flags_r[3] ? CAP_DEPTH : 32'd0);
            end
            default: begin
              calc_w[0] = RSP_NO_REND;
              calc_we   = 5'b00001;
            end
          endcase
        end
        CMD_CHEAT_ST: begin
          calc_w[0] = {8'd0, cheat_r, 16'd0};
        end
        CMD_CHEAT_ACK: begin
          if (size_r == 16'd0 || size_r == 16'd1) begin
            if (size_r == 16'd0) begin
              ack_cheat = cheat_r & USED_CHEATS_BIT;
            end else begin
              ack_cheat = cheat_r & ~word1_r[31:24];
            end
            calc_cheat = ack_cheat | frame_r;
            calc_w[0]  = {8'd0, calc_cheat, 16'd0};
          end else begin
            calc_w[0] = RSP_OVERSIZE;
          end
        end
        default: begin
          calc_w[0] = RSP_UNKNOWN;
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = merged;
    mem_raddr = addr_r;
    if (dp_cmd.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (dp_cmd.exec) begin
      mem_we    = (req_r == REQ_WRITE);
      mem_raddr = AW'(1);
    end else if (dp_cmd.cmd_wr) begin
      mem_we    = we_r[wr_cnt_r];
      mem_waddr = AW'(wr_cnt_r);
      mem_wdata = w_r[wr_cnt_r];
    end
    // Word 2 is held on the read port until the evaluation cycle uses it.
    if (dp_cmd.addr_go) begin
      mem_raddr = addr_nxt;
    end else if (dp_cmd.rd1 || dp_cmd.rd2) begin
      mem_raddr = AW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_read_data = out_data_r;

endmodule

// ----- rtl/core/mailbox_command_register_device.sv -----
// ----------------------------------------------------------------------------
// Mailbox command register device
// Reads, writes and mark requests take one transaction each: the index is
// wrapped to a store address, the access waits for a free result register and
// no new transaction is taken until it is through. A write that starts a
// command then holds the input for two reads of the word store, one evaluation
// step and five write-backs. After reset the store is cleared one word a cycle
// (MAILBOX_WORDS words, 16384 by default), input stalled; cfg writes are taken.
// ----------------------------------------------------------------------------
module mailbox_command_register_device
  import mcrd_pkg::*;
#(
  parameter int MAILBOX_WORDS = MAILBOX_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_word_index,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [DATA_W-1:0] in_write_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mcrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_sts    (dp_sts),
    .dp_cmd    (dp_cmd)
  );

  mcrd_dp #(
    .MAILBOX_WORDS (MAILBOX_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_cmd        (dp_cmd),
    .dp_sts        (dp_sts),
    .in_req_type   (in_req_type),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .in_write_mask (in_write_mask),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_read_data (out_read_data)
  );

endmodule

// ----- rtl/core/mcrd_checker.sv -----
// ----------------------------------------------------------------------------
// Mailbox port checker
// Watches the top-level ports for ordering and output-holding slips.
// ----------------------------------------------------------------------------
`include "mailbox_command_register_device_defines.svh"

module mcrd_port_checker
  import mcrd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_read_data
);

  // Only one transaction is in the block at a time.
  `MCRD_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  // A waiting result is held until it is taken.
  `MCRD_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(out_read_data))

  // Nothing is presented straight after reset.
  `MCRD_ASSERT_SAME(a_quiet_after_reset, $past(!rst_n), !out_valid)

endmodule

bind mailbox_command_register_device mcrd_port_checker u_mcrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data)
);
